>>> rtl/tracer_forcing_mass_clip_core_defines.svh
// Assertion macros shared by the RTL. They expect clk and rst in scope.
`ifndef TRACER_FORCING_MASS_CLIP_CORE_DEFINES_SVH
`define TRACER_FORCING_MASS_CLIP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TFMC_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tfmc: same-cycle check failed");
// next-cycle implication
`define TFMC_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tfmc: next-cycle check failed");
`else
`define TFMC_ASSERT_IMP(label, a, b)
`define TFMC_ASSERT_NXT(label, a, b)
`endif
`endif

>>> rtl/tfmc_pkg.sv
`timescale 1ns / 1ps

package tfmc_pkg;

  localparam int W         = 48;  // value, amount, forcing, state
  localparam int TS_W      = 47;  // time_step, reference_pressure
  localparam int CO_W      = 25;  // ai_delta, bi_delta
  localparam int COEF_BITS = 24;
  localparam int AW        = 96;  // product accumulator
  localparam int TW        = 49;  // thickness and remainder
  localparam int QB        = 49;  // quotient bits produced by the divider

  localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    OPC_START   = 2'd0,
    OPC_FORCE   = 2'd1,
    OPC_CLOSE   = 2'd2,
    OPC_CONVERT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CLIPPED = 2'd1,
    ST_THICK   = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_TIME_STEP  = 2'd0,
    REG_REF_PRESS  = 2'd1,
    REG_MOIST_MODE = 2'd2,
    REG_PHYS_LEVS  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    DP_NOP    = 4'd0,
    DP_START  = 4'd1,
    DP_CLOSE  = 4'd2,
    DP_ZERO   = 4'd3,
    DP_FINIT  = 4'd4,
    DP_MAC    = 4'd5,
    DP_FSTEP  = 4'd6,
    DP_FCLIP  = 4'd7,
    DP_FAPPLY = 4'd8,
    DP_CINIT  = 4'd9,
    DP_CTHICK = 4'd10,
    DP_DINIT  = 4'd11,
    DP_DIV    = 4'd12,
    DP_DFIN   = 4'd13,
    DP_CZERO  = 4'd14,
    DP_DSAT   = 4'd15
  } dp_op_t;

  typedef enum logic [2:0] {
    SEQ_GOTO      = 3'd0,
    SEQ_WAIT_IN   = 3'd1,
    SEQ_DISPATCH  = 3'd2,
    SEQ_LOOP      = 3'd3,
    SEQ_IF_THICK0 = 3'd4,
    SEQ_IF_DOVF   = 3'd5,
    SEQ_WAIT_OUT  = 3'd6
  } seq_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_IDLE   = 5'd0;
  localparam upc_t U_DISP   = 5'd1;
  localparam upc_t U_START  = 5'd2;
  localparam upc_t U_CLOSE  = 5'd3;
  localparam upc_t U_ZERO   = 5'd4;
  localparam upc_t U_FINIT  = 5'd5;
  localparam upc_t U_FMUL   = 5'd6;
  localparam upc_t U_FSTEP  = 5'd7;
  localparam upc_t U_FCLIP  = 5'd8;
  localparam upc_t U_FAPPLY = 5'd9;
  localparam upc_t U_CINIT  = 5'd10;
  localparam upc_t U_CMUL   = 5'd11;
  localparam upc_t U_CTHICK = 5'd12;
  localparam upc_t U_DINIT  = 5'd13;
  localparam upc_t U_DCHK   = 5'd14;
  localparam upc_t U_DIV    = 5'd15;
  localparam upc_t U_DFIN   = 5'd16;
  localparam upc_t U_CZERO  = 5'd17;
  localparam upc_t U_DSAT   = 5'd18;
  localparam upc_t U_RESULT = 5'd19;

  localparam int CNT_W = 6;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_NONE   = 6'd0;
  localparam cnt_t CNT_MUL_F  = 6'd47;  // one step per time_step bit
  localparam cnt_t CNT_MUL_C  = 6'd25;  // one step per coefficient bit
  localparam cnt_t CNT_DIV    = 6'd49;  // one step per quotient bit

  typedef struct packed {
    dp_op_t op;
    seq_t   seq;
    cnt_t   cnt_load;
    upc_t   target;
    upc_t   alt;
  } uword_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
  } dp_ctrl_t;

  typedef struct packed {
    opcode_t opc;
    logic    elem_ok;
    logic    thick_zero;
    logic    div_ovf;
  } dp_flags_t;

  typedef struct packed {
    logic [TS_W-1:0] time_step;
    logic [TS_W-1:0] reference_pressure;
    logic            moist_mode;
    logic [7:0]      physical_levels;
  } cfg_t;

  function automatic uword_t uw(dp_op_t op, seq_t seq, cnt_t cl, upc_t tgt, upc_t alt);
    uword_t w;
    w.op       = op;
    w.seq      = seq;
    w.cnt_load = cl;
    w.target   = tgt;
    w.alt      = alt;
    return w;
  endfunction

  // microcode store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      U_IDLE:   w = uw(DP_NOP,    SEQ_WAIT_IN,   CNT_NONE,  U_DISP,   U_IDLE);
      U_DISP:   w = uw(DP_NOP,    SEQ_DISPATCH,  CNT_NONE,  U_IDLE,   U_IDLE);
      U_START:  w = uw(DP_START,  SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_CLOSE:  w = uw(DP_CLOSE,  SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_ZERO:   w = uw(DP_ZERO,   SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_FINIT:  w = uw(DP_FINIT,  SEQ_GOTO,      CNT_MUL_F, U_FMUL,   U_IDLE);
      U_FMUL:   w = uw(DP_MAC,    SEQ_LOOP,      CNT_NONE,  U_FSTEP,  U_IDLE);
      U_FSTEP:  w = uw(DP_FSTEP,  SEQ_GOTO,      CNT_NONE,  U_FCLIP,  U_IDLE);
      U_FCLIP:  w = uw(DP_FCLIP,  SEQ_GOTO,      CNT_NONE,  U_FAPPLY, U_IDLE);
      U_FAPPLY: w = uw(DP_FAPPLY, SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_CINIT:  w = uw(DP_CINIT,  SEQ_GOTO,      CNT_MUL_C, U_CMUL,   U_IDLE);
      U_CMUL:   w = uw(DP_MAC,    SEQ_LOOP,      CNT_NONE,  U_CTHICK, U_IDLE);
      U_CTHICK: w = uw(DP_CTHICK, SEQ_GOTO,      CNT_NONE,  U_DINIT,  U_IDLE);
      U_DINIT:  w = uw(DP_DINIT,  SEQ_IF_THICK0, CNT_DIV,   U_DCHK,   U_CZERO);
      U_DCHK:   w = uw(DP_NOP,    SEQ_IF_DOVF,   CNT_NONE,  U_DIV,    U_DSAT);
      U_DIV:    w = uw(DP_DIV,    SEQ_LOOP,      CNT_NONE,  U_DFIN,   U_IDLE);
      U_DFIN:   w = uw(DP_DFIN,   SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_CZERO:  w = uw(DP_CZERO,  SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_DSAT:   w = uw(DP_DSAT,   SEQ_GOTO,      CNT_NONE,  U_RESULT, U_IDLE);
      U_RESULT: w = uw(DP_NOP,    SEQ_WAIT_OUT,  CNT_NONE,  U_IDLE,   U_IDLE);
      default:  w = uw(DP_NOP,    SEQ_GOTO,      CNT_NONE,  U_IDLE,   U_IDLE);
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(opcode_t opc, logic elem_ok);
    upc_t t;
    unique case (opc)
      OPC_START:   t = U_START;
      OPC_CLOSE:   t = U_CLOSE;
      OPC_FORCE:   t = elem_ok ? U_FINIT : U_ZERO;
      OPC_CONVERT: t = elem_ok ? U_CINIT : U_ZERO;
      default:     t = U_ZERO;
    endcase
    return t;
  endfunction

  // saturate a one-bit-grown sum back to W bits
  function automatic logic [W-1:0] sat_w(logic [W:0] v);
    logic [W-1:0] r;
    if (v[W] != v[W-1]) r = v[W] ? W_MIN : W_MAX;
    else r = v[W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/tfmc_dp.sv
`timescale 1ns / 1ps

module tfmc_dp #(
  parameter int TRACERS   = 8,
  parameter int LEVELS    = 128,
  parameter int FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tfmc_pkg::dp_ctrl_t                 ctrl,
  input  tfmc_pkg::cfg_t                     cfg,
  input  logic [1:0]                         opcode,
  input  logic [2:0]                         tracer,
  input  logic [6:0]                         level,
  input  logic signed [tfmc_pkg::W-1:0]      amount,
  input  logic signed [tfmc_pkg::W-1:0]      forcing,
  input  logic [tfmc_pkg::CO_W-1:0]          ai_delta,
  input  logic [tfmc_pkg::CO_W-1:0]          bi_delta,
  output tfmc_pkg::dp_flags_t                flags,
  output logic [tfmc_pkg::W-1:0]             res_value,
  output tfmc_pkg::status_t                  res_status
);

  localparam int W  = tfmc_pkg::W;
  localparam int AW = tfmc_pkg::AW;
  localparam int TW = tfmc_pkg::TW;
  localparam int QB = tfmc_pkg::QB;
  localparam int NW = W + FRAC_BITS;

  // latched item
  tfmc_pkg::opcode_t           opc_r;
  logic [2:0]                  tracer_r;
  logic [6:0]                  level_r;
  logic [W-1:0]                amount_r;
  logic [W-1:0]                forcing_r;
  logic [tfmc_pkg::CO_W-1:0]   ai_r;
  logic [tfmc_pkg::CO_W-1:0]   bi_r;

  // column state
  logic [W-1:0]                sp;
  logic [W-1:0]                sum;

  // shift-add multiplier
  logic signed [AW-1:0]        acc;
  logic [AW-1:0]               mca;
  logic [AW-1:0]               mcb;
  logic [tfmc_pkg::TS_W-1:0]   mpa;
  logic [tfmc_pkg::CO_W-1:0]   mpb;

  // force step
  logic [W-1:0]                step_r;
  logic                        ssat;
  logic                        clipped;

  // restoring divider
  logic [TW-1:0]               thick;
  logic [TW-1:0]               rem;
  logic [QB-1:0]               quo;

  logic [W-1:0]                res;
  tfmc_pkg::status_t           res_st;

  logic signed [AW-1:0]        acc_sh;
  logic                        step_fits;
  logic [W:0]                  am_st;
  logic [W:0]                  close_sum;
  logic [W:0]                  col_sum;
  logic                        col_on;
  logic [AW-1:0]               mac_next;
  logic [W-1:0]                mag;
  logic [NW-1:0]               num;
  logic [TW-1:0]               num_hi;
  logic [TW:0]                 r2;
  logic [TW:0]                 r2_diff;
  logic                        r2_ge;
  logic                        q_pos_sat;
  logic                        q_neg_sat;

  always_comb begin
    acc_sh    = acc >>> FRAC_BITS;
    step_fits = (acc_sh[AW-1:W-1] == '0) || (acc_sh[AW-1:W-1] == '1);
    am_st     = {amount_r[W-1], amount_r} + {step_r[W-1], step_r};
    close_sum = {sp[W-1], sp} + {sum[W-1], sum};
    col_sum   = {sum[W-1], sum} + {step_r[W-1], step_r};
    col_on    = cfg.moist_mode && (tracer_r == 3'd0)
                && ({1'b0, level_r} < cfg.physical_levels);
    mac_next  = acc + (mpa[0] ? mca : '0) + (mpb[0] ? mcb : '0);
    mag       = amount_r[W-1] ? ('0 - amount_r) : amount_r;
    num       = {mag, {FRAC_BITS{1'b0}}};
    num_hi    = TW'(num[NW-1:QB]);
    r2        = {rem, quo[QB-1]};
    r2_diff   = r2 - {1'b0, thick};
    r2_ge     = r2 >= {1'b0, thick};
    q_pos_sat = |quo[QB-1:W-1];
    q_neg_sat = quo[QB-1] | (quo[W-1] & (|quo[W-2:0]));
  end

  assign flags.opc        = opc_r;
  assign flags.elem_ok    = (32'(tracer_r) < TRACERS) && (32'(level_r) < LEVELS);
  assign flags.thick_zero = (thick == '0);
  // quotient would need more than QB bits
  assign flags.div_ovf    = (num_hi >= thick);

  assign res_value  = res;
  assign res_status = res_st;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      opc_r     <= tfmc_pkg::opcode_t'(opcode);
      tracer_r  <= tracer;
      level_r   <= level;
      amount_r  <= amount;
      forcing_r <= forcing;
      ai_r      <= ai_delta;
      bi_r      <= bi_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      sum <= '0;
    end else begin
      unique case (ctrl.op)
        tfmc_pkg::DP_START: begin
          sp  <= amount_r;
          sum <= '0;
        end
        tfmc_pkg::DP_CLOSE: begin
          sp  <= tfmc_pkg::sat_w(close_sum);
          sum <= '0;
        end
        tfmc_pkg::DP_FAPPLY: begin
          if (col_on) sum <= tfmc_pkg::sat_w(col_sum);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      tfmc_pkg::DP_START: begin
        res    <= amount_r;
        res_st <= tfmc_pkg::ST_OK;
      end
      tfmc_pkg::DP_CLOSE: begin
        res    <= tfmc_pkg::sat_w(close_sum);
        res_st <= (close_sum[W] != close_sum[W-1]) ? tfmc_pkg::ST_SAT : tfmc_pkg::ST_OK;
      end
      tfmc_pkg::DP_ZERO: begin
        res    <= '0;
        res_st <= tfmc_pkg::ST_OK;
      end
      tfmc_pkg::DP_FINIT: begin
        acc <= '0;
        mca <= {{(AW-W){forcing_r[W-1]}}, forcing_r};
        mcb <= '0;
        mpa <= cfg.time_step;
        mpb <= '0;
      end
      tfmc_pkg::DP_CINIT: begin
        acc <= '0;
        mca <= {{(AW-tfmc_pkg::TS_W){1'b0}}, cfg.reference_pressure};
        mcb <= {{(AW-W){sp[W-1]}}, sp};
        mpa <= {{(tfmc_pkg::TS_W-tfmc_pkg::CO_W){1'b0}}, ai_r};
        mpb <= bi_r;
      end
      tfmc_pkg::DP_MAC: begin
        acc <= mac_next;
        mca <= {mca[AW-2:0], 1'b0};
        mcb <= {mcb[AW-2:0], 1'b0};
        mpa <= {1'b0, mpa[tfmc_pkg::TS_W-1:1]};
        mpb <= {1'b0, mpb[tfmc_pkg::CO_W-1:1]};
      end
      tfmc_pkg::DP_FSTEP: begin
        step_r  <= step_fits ? acc_sh[W-1:0]
                             : (acc_sh[AW-1] ? tfmc_pkg::W_MIN : tfmc_pkg::W_MAX);
        ssat    <= !step_fits;
        clipped <= 1'b0;
      end
      tfmc_pkg::DP_FCLIP: begin
        // a removal larger than the mass takes only what is there
        if (step_r[W-1] && am_st[W]) begin
          step_r  <= amount_r[W-1] ? '0 : ('0 - amount_r);
          clipped <= 1'b1;
          ssat    <= 1'b0;
        end
      end
      tfmc_pkg::DP_FAPPLY: begin
        res <= tfmc_pkg::sat_w(am_st);
        if (ssat || (am_st[W] != am_st[W-1])
            || (col_on && (col_sum[W] != col_sum[W-1]))) begin
          res_st <= tfmc_pkg::ST_SAT;
        end else begin
          res_st <= clipped ? tfmc_pkg::ST_CLIPPED : tfmc_pkg::ST_OK;
        end
      end
      tfmc_pkg::DP_CTHICK: begin
        thick <= acc[AW-1] ? '0 : acc[tfmc_pkg::COEF_BITS +: TW];
      end
      tfmc_pkg::DP_DINIT: begin
        rem <= num_hi;
        quo <= num[QB-1:0];
      end
      tfmc_pkg::DP_DIV: begin
        rem <= r2_ge ? r2_diff[TW-1:0] : r2[TW-1:0];
        quo <= {quo[QB-2:0], r2_ge};
      end
      tfmc_pkg::DP_DFIN: begin
        if (amount_r[W-1]) begin
          res    <= q_neg_sat ? tfmc_pkg::W_MIN : ('0 - quo[W-1:0]);
          res_st <= q_neg_sat ? tfmc_pkg::ST_SAT : tfmc_pkg::ST_OK;
        end else begin
          res    <= q_pos_sat ? tfmc_pkg::W_MAX : quo[W-1:0];
          res_st <= q_pos_sat ? tfmc_pkg::ST_SAT : tfmc_pkg::ST_OK;
        end
      end
      tfmc_pkg::DP_CZERO: begin
        res    <= '0;
        res_st <= tfmc_pkg::ST_THICK;
      end
      tfmc_pkg::DP_DSAT: begin
        res    <= amount_r[W-1] ? tfmc_pkg::W_MIN : tfmc_pkg::W_MAX;
        res_st <= tfmc_pkg::ST_SAT;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tracer_forcing_mass_clip_core.sv
`timescale 1ns / 1ps
// Tracer forcing for one grid column at a time.
// Input channel (item_valid/item_stall) carries opcode, tracer, level, amount,
// forcing, ai_delta, bi_delta; a transfer happens when item_valid is high and
// item_stall is low. Each item gives exactly one result on the output channel
// (result_valid/result_stall): value and status.
// Registers sit on an APB port with 64-bit data, register i at byte 8*i.
// Items are worked one at a time by a microcoded sequencer driving a
// shift-add multiplier and a restoring divider, one bit per cycle.
// Start, close and out-of-range items go straight to the result; force runs
// 47 multiply steps, one per time_step bit; convert runs 25 multiply steps,
// then 49 divide steps, skipping the divide when the thickness is not positive.
// A finished result waits in the output register while the next item is
// taken; only when a new result is ready and the old one is still stalled does
// the sequencer hold, and item_stall stays high until the result moves.
// Reset clears the sequencer, result_valid, the column state and
// restores register defaults; no clearing pass is needed.
`include "tracer_forcing_mass_clip_core_defines.svh"

module tracer_forcing_mass_clip_core #(
  parameter int TRACERS   = 8,
  parameter int LEVELS    = 128,
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         opcode,
  input  logic [2:0]         tracer,
  input  logic [6:0]         level,
  input  logic signed [47:0] amount,
  input  logic signed [47:0] forcing,
  input  logic [24:0]        ai_delta,
  input  logic [24:0]        bi_delta,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [47:0] value,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int TS_W = tfmc_pkg::TS_W;

  logic [TS_W-1:0] time_step;
  logic [TS_W-1:0] reference_pressure;
  logic            moist_mode;
  logic [7:0]      physical_levels;

  tfmc_pkg::cfg_t      cfg;
  tfmc_pkg::reg_idx_t  reg_sel;
  logic                cfg_write;

  tfmc_pkg::upc_t      upc;
  tfmc_pkg::upc_t      upc_next;
  tfmc_pkg::cnt_t      cnt;
  tfmc_pkg::cnt_t      cnt_next;
  tfmc_pkg::uword_t    uw;
  tfmc_pkg::dp_ctrl_t  ctrl;
  tfmc_pkg::dp_flags_t flags;

  logic [47:0]         res_value;
  tfmc_pkg::status_t   res_status;
  logic                item_accept;
  logic                out_free;
  logic                at_idle;
  logic                at_result;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = tfmc_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step          <= '0;
      reference_pressure <= 47'd1677721600000;
      moist_mode         <= 1'b1;
      physical_levels    <= 8'd72;
    end else if (cfg_write) begin
      unique case (reg_sel)
        tfmc_pkg::REG_TIME_STEP:  time_step          <= pwdata[TS_W-1:0];
        tfmc_pkg::REG_REF_PRESS:  reference_pressure <= pwdata[TS_W-1:0];
        tfmc_pkg::REG_MOIST_MODE: moist_mode         <= pwdata[0];
        tfmc_pkg::REG_PHYS_LEVS:  physical_levels    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tfmc_pkg::REG_TIME_STEP:  prdata = {{(64-TS_W){1'b0}}, time_step};
      tfmc_pkg::REG_REF_PRESS:  prdata = {{(64-TS_W){1'b0}}, reference_pressure};
      tfmc_pkg::REG_MOIST_MODE: prdata = {63'd0, moist_mode};
      tfmc_pkg::REG_PHYS_LEVS:  prdata = {56'd0, physical_levels};
      default:                  prdata = '0;
    endcase
  end

  assign cfg.time_step          = time_step;
  assign cfg.reference_pressure = reference_pressure;
  assign cfg.moist_mode         = moist_mode;
  assign cfg.physical_levels    = physical_levels;

  // sequencer
  assign at_idle     = (upc == tfmc_pkg::U_IDLE);
  assign at_result   = (upc == tfmc_pkg::U_RESULT);
  assign item_stall  = !at_idle;
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;
  assign uw          = tfmc_pkg::ucode(upc);
  assign ctrl.op     = uw.op;
  assign ctrl.load   = item_accept;

  always_comb begin
    upc_next = upc;
    cnt_next = (uw.cnt_load != tfmc_pkg::CNT_NONE) ? uw.cnt_load : cnt;
    unique case (uw.seq)
      tfmc_pkg::SEQ_GOTO:      upc_next = uw.target;
      tfmc_pkg::SEQ_WAIT_IN:   if (item_accept) upc_next = uw.target;
      tfmc_pkg::SEQ_DISPATCH:  upc_next = tfmc_pkg::dispatch(flags.opc, flags.elem_ok);
      tfmc_pkg::SEQ_LOOP: begin
        cnt_next = cnt - tfmc_pkg::cnt_t'(1);
        if (cnt == tfmc_pkg::cnt_t'(1)) upc_next = uw.target;
      end
      tfmc_pkg::SEQ_IF_THICK0: upc_next = flags.thick_zero ? uw.alt : uw.target;
      tfmc_pkg::SEQ_IF_DOVF:   upc_next = flags.div_ovf ? uw.alt : uw.target;
      tfmc_pkg::SEQ_WAIT_OUT:  if (out_free) upc_next = uw.target;
      default:                 upc_next = tfmc_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= tfmc_pkg::U_IDLE;
      cnt <= '0;
    end else begin
      upc <= upc_next;
      cnt <= cnt_next;
    end
  end

  tfmc_dp #(
    .TRACERS   (TRACERS),
    .LEVELS    (LEVELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg        (cfg),
    .opcode     (opcode),
    .tracer     (tracer),
    .level      (level),
    .amount     (amount),
    .forcing    (forcing),
    .ai_delta   (ai_delta),
    .bi_delta   (bi_delta),
    .flags      (flags),
    .res_value  (res_value),
    .res_status (res_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (at_result && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (at_result && out_free) begin
      value  <= res_value;
      status <= res_status;
    end
  end

  `TFMC_ASSERT_NXT(a_idle_waits, at_idle && !item_accept, at_idle)
  `TFMC_ASSERT_NXT(a_result_held, at_result && result_valid && result_stall, at_result)
  `TFMC_ASSERT_IMP(a_loop_count, uw.seq == tfmc_pkg::SEQ_LOOP, cnt != '0)

endmodule

>>> verif/tb_tracer_forcing_mass_clip_core.sv
`timescale 1ns / 1ps

module tb_tracer_forcing_mass_clip_core;

  localparam int FRAC = 24;
  localparam logic signed [47:0] FX_ONE = 48'sd16777216;
  localparam logic signed [47:0] FX_MAX = tfmc_pkg::W_MAX;
  localparam logic signed [47:0] FX_MIN = tfmc_pkg::W_MIN;
  localparam logic [46:0] PS0_DEFAULT = 47'd1677721600000;
  localparam logic [46:0] MAX47 = {47{1'b1}};
  localparam logic signed [127:0] MAX_WIDE = {{80{1'b0}}, tfmc_pkg::W_MAX};
  localparam logic signed [127:0] MIN_WIDE = {{80{1'b1}}, tfmc_pkg::W_MIN};

  typedef struct packed {
    tfmc_pkg::opcode_t  opc;
    logic [2:0]         trc;
    logic [6:0]         lvl;
    logic signed [47:0] amt;
    logic signed [47:0] frc;
    logic [24:0]        ai;
    logic [24:0]        bi;
  } column_item_t;

  typedef struct packed {
    logic signed [47:0] value;
    tfmc_pkg::status_t  status;
  } mass_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  column_item_t cur_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [47:0] value;
  logic [1:0] status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  // predictor copy of the registers and the column state
  logic [46:0] cfg_dt = '0;
  logic [46:0] cfg_ps0 = PS0_DEFAULT;
  logic cfg_moist = 1'b1;
  logic [7:0] cfg_levels = 8'd72;
  logic signed [47:0] col_pressure = '0;
  logic signed [47:0] col_corr = '0;

  column_item_t pending_items[$];
  mass_result_t expected_results[$];
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_run = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  bit idle_on = 1'b0;
  bit hold_go = 1'b0;
  logic hold_off = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  tracer_forcing_mass_clip_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .opcode(cur_item.opc), .tracer(cur_item.trc), .level(cur_item.lvl),
    .amount(cur_item.amt), .forcing(cur_item.frc),
    .ai_delta(cur_item.ai), .bi_delta(cur_item.bi),
    .result_valid(result_valid), .result_stall(result_stall),
    .value(value), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic logic signed [127:0] wide(logic signed [47:0] v);
    return {{80{v[47]}}, v};
  endfunction

  function automatic logic signed [47:0] sat_wide(logic signed [127:0] x, inout bit ovf);
    if (x > MAX_WIDE) begin
      ovf = 1'b1;
      return FX_MAX;
    end
    if (x < MIN_WIDE) begin
      ovf = 1'b1;
      return FX_MIN;
    end
    return x[47:0];
  endfunction

  // Tracer and level ports cannot exceed TRACERS/LEVELS at the default sizes,
  // so every force and convert element is in range.
  function automatic mass_result_t apply_column_item(column_item_t it);
    mass_result_t r;
    logic signed [47:0] amt, step;
    logic signed [127:0] prod, acc;
    logic [127:0] num, quo;
    logic [63:0] thick;
    bit ssat, msat, csat, clipped;
    amt = it.amt;
    ssat = 0;
    msat = 0;
    csat = 0;
    clipped = 0;
    r.value = '0;
    r.status = tfmc_pkg::ST_OK;
    case (it.opc)
      tfmc_pkg::OPC_START: begin
        col_pressure = amt;
        col_corr = '0;
        r.value = amt;
      end
      tfmc_pkg::OPC_CLOSE: begin
        col_pressure = sat_wide(wide(col_pressure) + wide(col_corr), msat);
        col_corr = '0;
        r.value = col_pressure;
        if (msat) r.status = tfmc_pkg::ST_SAT;
      end
      tfmc_pkg::OPC_FORCE: begin
        prod = $signed({81'd0, cfg_dt}) * wide(it.frc);
        step = sat_wide(prod >>> FRAC, ssat);
        if (step < 0 && wide(amt) + wide(step) < 0) begin
          step = amt[47] ? 48'sd0 : -amt;
          clipped = 1;
          ssat = 0;
        end
        r.value = sat_wide(wide(amt) + wide(step), msat);
        if (cfg_moist && it.trc == 0 && {1'b0, it.lvl} < cfg_levels)
          col_corr = sat_wide(wide(col_corr) + wide(step), csat);
        if (ssat || msat || csat) r.status = tfmc_pkg::ST_SAT;
        else if (clipped) r.status = tfmc_pkg::ST_CLIPPED;
      end
      default: begin
        acc = $signed({103'd0, it.ai}) * $signed({81'd0, cfg_ps0})
            + $signed({103'd0, it.bi}) * wide(col_pressure);
        thick = acc[127] ? 64'd0 : acc[87:24];
        if (thick == 0) begin
          r.status = tfmc_pkg::ST_THICK;
        end else begin
          num = amt[47] ? -wide(amt) : wide(amt);
          num = num << FRAC;
          quo = num / {64'd0, thick};
          if (amt[47]) quo = -quo;
          r.value = sat_wide($signed(quo), msat);
          if (msat) r.status = tfmc_pkg::ST_SAT;
        end
      end
    endcase
    return r;
  endfunction

  // input side: one pending item per transfer, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left <= 0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left != 0) begin
        item_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          item_valid <= 1'b0;
          gap_left <= $urandom_range(0, 9);
        end else begin
          cur_item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      expected_results.push_back(apply_column_item(cur_item));
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      result_stall <= 1'b1;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    mass_result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      status_seen[status]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: value %h status %0d", results_seen, value, status);
      end else begin
        want = expected_results.pop_front();
        if (value !== want.value || status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: got value %h status %0d, expected value %h status %0d",
                     results_seen, value, status, want.value, want.status);
        end
      end
    end
  end

  task automatic push_item(tfmc_pkg::opcode_t opc, int unsigned trc, int unsigned lvl,
                           logic signed [47:0] amt, logic signed [47:0] frc,
                           logic [24:0] ai, logic [24:0] bi);
    column_item_t it;
    it.opc = opc;
    it.trc = 3'(trc);
    it.lvl = 7'(lvl);
    it.amt = amt;
    it.frc = frc;
    it.ai = ai;
    it.bi = bi;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(tfmc_pkg::reg_idx_t idx, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tfmc_pkg::REG_TIME_STEP:  cfg_dt = data[46:0];
      tfmc_pkg::REG_REF_PRESS:  cfg_ps0 = data[46:0];
      tfmc_pkg::REG_MOIST_MODE: cfg_moist = data[0];
      tfmc_pkg::REG_PHYS_LEVS:  cfg_levels = data[7:0];
    endcase
  endtask

  task automatic set_config(logic [46:0] dt, logic [46:0] ps0, bit moist,
                            logic [7:0] levels);
    write_reg(tfmc_pkg::REG_TIME_STEP, {17'd0, dt});
    write_reg(tfmc_pkg::REG_REF_PRESS, {17'd0, ps0});
    write_reg(tfmc_pkg::REG_MOIST_MODE, {63'd0, moist});
    write_reg(tfmc_pkg::REG_PHYS_LEVS, {56'd0, levels});
    settings_run++;
  endtask

  task automatic drain_column_work();
    while (results_seen < items_queued) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [47:0] pick_value(int unsigned mag_bits);
    logic [63:0] r;
    logic signed [47:0] v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: v = FX_MAX;
      1: v = FX_MIN;
      2: v = '0;
      3: v = -48'sd1;
      4, 5: v = r[47:0];
      default: begin
        v = r[47:0] & 48'((64'd1 << mag_bits) - 64'd1);
        if (r[63]) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [24:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 25'd16777216;
      2: return 25'($urandom);
      default: return 25'($urandom_range(0, 16777216));
    endcase
  endfunction

  // one column: start, a run of elements, usually a close, with some stray items
  task automatic queue_column(int unsigned n_elems);
    logic signed [47:0] ps;
    int unsigned trc;
    if ($urandom_range(0, 3) != 0)
      ps = (48'($urandom_range(1 << 15, 1 << 18)) << FRAC) | 48'($urandom_range(0, 1 << 24));
    else
      ps = pick_value(47);
    push_item(tfmc_pkg::OPC_START, 0, 0, ps, pick_value(47), pick_coef(), pick_coef());
    repeat (n_elems) begin
      trc = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
      case ($urandom_range(0, 19))
        0: push_item(tfmc_pkg::opcode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                     $urandom_range(0, 127), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 25'($urandom), 25'($urandom));
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
          push_item(tfmc_pkg::OPC_FORCE, trc, $urandom_range(0, 127), pick_value(36),
                    pick_value(32), pick_coef(), pick_coef());
        default:
          push_item(tfmc_pkg::OPC_CONVERT, trc, $urandom_range(0, 127), pick_value(40),
                    pick_value(40), pick_coef(), pick_coef());
      endcase
    end
    if ($urandom_range(0, 9) != 0)
      push_item(tfmc_pkg::OPC_CLOSE, 0, 0, pick_value(47), pick_value(47), pick_coef(),
                pick_coef());
  endtask

  initial begin
    int unsigned target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unit step, default pressure and levels
    set_config(FX_ONE, PS0_DEFAULT, 1'b1, 8'd72);
    push_item(tfmc_pkg::OPC_START, 0, 0, 1000 * FX_ONE, 0, 0, 0);
    push_item(tfmc_pkg::OPC_FORCE, 0, 0, 5 * FX_ONE, 2 * FX_ONE, 0, 0);
    push_item(tfmc_pkg::OPC_FORCE, 0, 1, 3 * FX_ONE, -5 * FX_ONE, 0, 0);  // clip to -mass
    push_item(tfmc_pkg::OPC_FORCE, 0, 2, -4 * FX_ONE, -FX_ONE, 0, 0);     // already negative
    push_item(tfmc_pkg::OPC_FORCE, 0, 100, FX_ONE, FX_ONE, 0, 0);         // above phys levels
    push_item(tfmc_pkg::OPC_FORCE, 5, 127, FX_MAX, FX_MAX, 25'h1FFFFFF, 25'h1FFFFFF);
    push_item(tfmc_pkg::OPC_FORCE, 7, 3, FX_MIN, FX_MIN, 0, 0);
    push_item(tfmc_pkg::OPC_CLOSE, 0, 0, 0, 0, 0, 0);
    push_item(tfmc_pkg::OPC_CONVERT, 1, 5, 10 * FX_ONE, 0, 25'd16777216, 0);
    push_item(tfmc_pkg::OPC_CONVERT, 2, 6, FX_ONE, 0, 0, 0);              // zero thickness
    push_item(tfmc_pkg::OPC_START, 0, 0, 48'sd1, 0, 0, 0);
    push_item(tfmc_pkg::OPC_CONVERT, 0, 0, FX_MAX, 0, 0, 25'd16777216);   // quotient overflows
    push_item(tfmc_pkg::OPC_CONVERT, 0, 0, FX_MIN, 0, 0, 25'd16777216);
    push_item(tfmc_pkg::OPC_START, 0, 0, -5 * FX_ONE, 0, 0, 0);
    push_item(tfmc_pkg::OPC_CONVERT, 3, 9, FX_ONE, 0, 0, 25'd16777216);   // negative thickness
    push_item(tfmc_pkg::OPC_START, 0, 0, FX_MAX, 0, 0, 0);
    push_item(tfmc_pkg::OPC_FORCE, 0, 0, 0, FX_MAX, 0, 0);
    push_item(tfmc_pkg::OPC_FORCE, 0, 0, 0, FX_MAX, 0, 0);                // correction saturates
    push_item(tfmc_pkg::OPC_CLOSE, 0, 0, 0, 0, 0, 0);                     // pressure saturates
    drain_column_work();

    // largest step, one physical level
    set_config(MAX47, PS0_DEFAULT, 1'b1, 8'd1);
    push_item(tfmc_pkg::OPC_START, 0, 0, FX_ONE, 0, 0, 0);
    push_item(tfmc_pkg::OPC_FORCE, 0, 0, FX_ONE, 48'sd1073741824, 0, 0);  // step saturates
    push_item(tfmc_pkg::OPC_FORCE, 0, 1, FX_MAX, -48'sd1073741824, 0, 0); // saturated, clipped
    push_item(tfmc_pkg::OPC_CLOSE, 0, 0, 0, 0, 0, 0);
    push_item(tfmc_pkg::OPC_CONVERT, 4, 64, 0, 0, 25'd16777216, 25'd16777216);
    drain_column_work();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(FX_ONE, PS0_DEFAULT, 1'b1, 8'd72);
        1: set_config(47'($urandom_range(0, 1 << 30)), '0, 1'b1, 8'd128);
        2: set_config('0, MAX47, 1'b0, 8'($urandom_range(1, 128)));
        3: set_config(47'({$urandom, $urandom}), 47'({$urandom, $urandom}), 1'b1, 8'd1);
        4: set_config(47'($urandom_range(1 << 20, 1 << 28)), PS0_DEFAULT + 47'($urandom),
                      1'b1, 8'($urandom_range(1, 128)));
        default: set_config(FX_ONE, PS0_DEFAULT, 1'b1, 8'd72);
      endcase
      idle_on = (p != 5);
      target = items_queued + 275;
      while (items_queued < target) queue_column($urandom_range(1, 12));
      if (p == 4) hold_go = 1'b1;
      drain_column_work();
    end

    repeat (100) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("%0d items over %0d register settings, %0d results checked, %0d mismatches",
             items_queued, settings_run, results_seen, mismatches);
    $display("status mix: %0d ok, %0d clipped, %0d bad thickness, %0d saturated",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d of %0d results seen", results_seen, items_queued);
    $display("FAIL");
    $finish;
  end

endmodule
